// ----- rtl/deadline_timer_queue_top_macros.svh -----
// ----------------------------------------------------------------------------
// deadline_timer_queue_top_macros
// Assertion helpers for the deadline timer queue; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef DEADLINE_TIMER_QUEUE_TOP_MACROS_SVH
`define DEADLINE_TIMER_QUEUE_TOP_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define DTQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dtq assertion failed");
// next-cycle implication
`define DTQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dtq assertion failed");
`else
`define DTQ_ASSERT_NOW(label, ante, cons)
`define DTQ_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- rtl/dtq_pkg.sv -----
// ----------------------------------------------------------------------------
// dtq_pkg
// Shared types and constants of the deadline timer queue.
// ----------------------------------------------------------------------------
package dtq_pkg;

  localparam int unsigned ID_W   = 6;
  localparam int unsigned SEQ_W  = 48;
  localparam int unsigned PER_W  = 32;
  localparam int unsigned NOW_W  = 48;
  localparam int unsigned WAIT_W = 48;

  typedef enum logic [2:0] {
    KIND_ADD     = 3'd0,
    KIND_CANCEL  = 3'd1,
    KIND_REFRESH = 3'd2,
    KIND_RESET   = 3'd3,
    KIND_EXPIRE  = 3'd4,
    KIND_QUERY   = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_NOT_PENDING = 2'd1,
    ST_BUSY        = 2'd2,
    ST_NONE_DUE    = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_REMOVE,
    S_INSERT,
    S_RESP,
    S_POP,
    S_RCALC,
    S_RINS,
    S_EMIT
  } state_e;

  // chain command for one cycle
  typedef struct packed {
    logic ins;
    logic rem;
  } dtq_cmd_t;

endpackage

// ----- rtl/dtq_cell.sv -----
// ----------------------------------------------------------------------------
// dtq_cell
// One slot of the sorted timer chain: holds one timer, shifts on insert/remove.
// ----------------------------------------------------------------------------
module dtq_cell #(
  parameter int unsigned TIME_BITS = 48
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  dtq_pkg::dtq_cmd_t         cmd_i,
  input  logic [dtq_pkg::ID_W-1:0]  new_id_i,
  input  logic [TIME_BITS-1:0]      new_dl_i,
  input  logic [dtq_pkg::SEQ_W-1:0] new_seq_i,
  input  logic [dtq_pkg::PER_W-1:0] new_per_i,
  input  logic                      new_rep_i,
  input  logic [dtq_pkg::ID_W-1:0]  rem_id_i,
  input  logic                      left_less_i,
  input  logic                      left_pm_i,
  input  logic                      left_valid_i,
  input  logic [dtq_pkg::ID_W-1:0]  left_id_i,
  input  logic [TIME_BITS-1:0]      left_dl_i,
  input  logic [dtq_pkg::SEQ_W-1:0] left_seq_i,
  input  logic [dtq_pkg::PER_W-1:0] left_per_i,
  input  logic                      left_rep_i,
  input  logic                      right_valid_i,
  input  logic [dtq_pkg::ID_W-1:0]  right_id_i,
  input  logic [TIME_BITS-1:0]      right_dl_i,
  input  logic [dtq_pkg::SEQ_W-1:0] right_seq_i,
  input  logic [dtq_pkg::PER_W-1:0] right_per_i,
  input  logic                      right_rep_i,
  output logic                      valid_o,
  output logic [dtq_pkg::ID_W-1:0]  id_o,
  output logic [TIME_BITS-1:0]      dl_o,
  output logic [dtq_pkg::SEQ_W-1:0] seq_o,
  output logic [dtq_pkg::PER_W-1:0] per_o,
  output logic                      rep_o,
  output logic                      less_o,
  output logic                      pm_o
);
  import dtq_pkg::*;

  logic              valid_q, valid_d;
  logic [ID_W-1:0]   id_q, id_d;
  logic [TIME_BITS-1:0] dl_q, dl_d;
  logic [SEQ_W-1:0]  seq_q, seq_d;
  logic [PER_W-1:0]  per_q, per_d;
  logic              rep_q, rep_d;
  logic              less, pm;

  // empty slots count as later than anything
  assign less = !valid_q || (new_dl_i < dl_q) || ((new_dl_i == dl_q) && (new_seq_i < seq_q));
  assign pm   = left_pm_i || (valid_q && (id_q == rem_id_i));

  always_comb begin
    valid_d = valid_q;
    id_d    = id_q;
    dl_d    = dl_q;
    seq_d   = seq_q;
    per_d   = per_q;
    rep_d   = rep_q;
    if (cmd_i.ins && less) begin
      valid_d = 1'b1;
      if (left_less_i) begin
        valid_d = left_valid_i;
        id_d  = left_id_i;
        dl_d  = left_dl_i;
        seq_d = left_seq_i;
        per_d = left_per_i;
        rep_d = left_rep_i;
      end else begin
        id_d  = new_id_i;
        dl_d  = new_dl_i;
        seq_d = new_seq_i;
        per_d = new_per_i;
        rep_d = new_rep_i;
      end
    end else if (cmd_i.rem && pm) begin
      valid_d = right_valid_i;
      id_d    = right_id_i;
      dl_d    = right_dl_i;
      seq_d   = right_seq_i;
      per_d   = right_per_i;
      rep_d   = right_rep_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q  <= id_d;
    dl_q  <= dl_d;
    seq_q <= seq_d;
    per_q <= per_d;
    rep_q <= rep_d;
  end

  assign valid_o = valid_q;
  assign id_o    = id_q;
  assign dl_o    = dl_q;
  assign seq_o   = seq_q;
  assign per_o   = per_q;
  assign rep_o   = rep_q;
  assign less_o  = less;
  assign pm_o    = pm;

endmodule

// ----- rtl/dtq_chain.sv -----
// ----------------------------------------------------------------------------
// dtq_chain
// Row of timer cells kept in deadline order, with head and by-id lookup.
// ----------------------------------------------------------------------------
module dtq_chain #(
  parameter int unsigned TIMERS    = 32,
  parameter int unsigned TIME_BITS = 48
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  dtq_pkg::dtq_cmd_t         cmd_i,
  input  logic [dtq_pkg::ID_W-1:0]  new_id_i,
  input  logic [TIME_BITS-1:0]      new_dl_i,
  input  logic [dtq_pkg::SEQ_W-1:0] new_seq_i,
  input  logic [dtq_pkg::PER_W-1:0] new_per_i,
  input  logic                      new_rep_i,
  input  logic [dtq_pkg::ID_W-1:0]  rem_id_i,
  input  logic [dtq_pkg::ID_W-1:0]  lk_id_i,
  output logic                      lk_hit_o,
  output logic [TIME_BITS-1:0]      lk_dl_o,
  output logic [dtq_pkg::PER_W-1:0] lk_per_o,
  output logic                      lk_rep_o,
  output logic                      hd_valid_o,
  output logic [dtq_pkg::ID_W-1:0]  hd_id_o,
  output logic [TIME_BITS-1:0]      hd_dl_o,
  output logic [dtq_pkg::PER_W-1:0] hd_per_o,
  output logic                      hd_rep_o,
  output logic                      front_o
);
  import dtq_pkg::*;

  logic              v    [TIMERS];
  logic [ID_W-1:0]   id   [TIMERS];
  logic [TIME_BITS-1:0] dl [TIMERS];
  logic [SEQ_W-1:0]  seq  [TIMERS];
  logic [PER_W-1:0]  per  [TIMERS];
  logic              rep  [TIMERS];
  logic              less [TIMERS];
  logic              pm   [TIMERS];

  for (genvar i = 0; i < TIMERS; i++) begin : g_cell
    logic                 l_less, l_pm, l_valid, l_rep, r_valid, r_rep;
    logic [ID_W-1:0]      l_id, r_id;
    logic [TIME_BITS-1:0] l_dl, r_dl;
    logic [SEQ_W-1:0]     l_seq, r_seq;
    logic [PER_W-1:0]     l_per, r_per;

    if (i == 0) begin : g_first
      assign l_less  = 1'b0;
      assign l_pm    = 1'b0;
      assign l_valid = 1'b0;
      assign l_id    = '0;
      assign l_dl    = '0;
      assign l_seq   = '0;
      assign l_per   = '0;
      assign l_rep   = 1'b0;
    end else begin : g_mid
      assign l_less  = less[i-1];
      assign l_pm    = pm[i-1];
      assign l_valid = v[i-1];
      assign l_id    = id[i-1];
      assign l_dl    = dl[i-1];
      assign l_seq   = seq[i-1];
      assign l_per   = per[i-1];
      assign l_rep   = rep[i-1];
    end
    if (i == TIMERS - 1) begin : g_last
      assign r_valid = 1'b0;
      assign r_id    = '0;
      assign r_dl    = '0;
      assign r_seq   = '0;
      assign r_per   = '0;
      assign r_rep   = 1'b0;
    end else begin : g_inner
      assign r_valid = v[i+1];
      assign r_id    = id[i+1];
      assign r_dl    = dl[i+1];
      assign r_seq   = seq[i+1];
      assign r_per   = per[i+1];
      assign r_rep   = rep[i+1];
    end

    dtq_cell #(.TIME_BITS(TIME_BITS)) u_cell (
      .clk_i, .rst_ni, .cmd_i,
      .new_id_i, .new_dl_i, .new_seq_i, .new_per_i, .new_rep_i, .rem_id_i,
      .left_less_i(l_less), .left_pm_i(l_pm), .left_valid_i(l_valid),
      .left_id_i(l_id), .left_dl_i(l_dl),
      .left_seq_i(l_seq), .left_per_i(l_per), .left_rep_i(l_rep),
      .right_valid_i(r_valid), .right_id_i(r_id), .right_dl_i(r_dl),
      .right_seq_i(r_seq), .right_per_i(r_per), .right_rep_i(r_rep),
      .valid_o(v[i]), .id_o(id[i]), .dl_o(dl[i]), .seq_o(seq[i]),
      .per_o(per[i]), .rep_o(rep[i]), .less_o(less[i]), .pm_o(pm[i])
    );
  end

  // ids are unique, so at most one cell hits: OR the hit fields
  always_comb begin
    lk_hit_o = 1'b0;
    lk_dl_o  = '0;
    lk_per_o = '0;
    lk_rep_o = 1'b0;
    for (int i = 0; i < TIMERS; i++) begin
      if (v[i] && (id[i] == lk_id_i)) begin
        lk_hit_o = 1'b1;
        lk_dl_o  = lk_dl_o | dl[i];
        lk_per_o = lk_per_o | per[i];
        lk_rep_o = lk_rep_o | rep[i];
      end
    end
  end

  assign hd_valid_o = v[0];
  assign hd_id_o    = id[0];
  assign hd_dl_o    = dl[0];
  assign hd_per_o   = per[0];
  assign hd_rep_o   = rep[0];
  assign front_o    = less[0];

endmodule

// ----- rtl/deadline_timer_queue_top.sv -----
// Path to the result word: add/refresh/reset DECODE, REMOVE, INSERT, RESP; cancel
// DECODE, REMOVE, RESP; query and rejected or ignored words DECODE, RESP; expire
// DECODE, POP, then RESP if none due, else RCALC (RINS rearms recurring ones) and
// EMIT, one word per cycle unless stalled; the chain moves one timer per cycle.
// A new word is taken from the cycle after the last result word is loaded.
// Reset (rst_ni, async low) empties the chain and clears the sequence counter.
// ----------------------------------------------------------------------------
// deadline_timer_queue_top
// Timer queue sorted by deadline in a row of cells, with command sequencer.
// ----------------------------------------------------------------------------
`include "deadline_timer_queue_top_macros.svh"

module deadline_timer_queue_top #(
  parameter int unsigned TIMERS    = 32,
  parameter int unsigned TIME_BITS = 48
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [2:0]                 kind_i,
  input  logic [dtq_pkg::NOW_W-1:0]  now_ms_i,
  input  logic [dtq_pkg::ID_W-1:0]   timer_id_i,
  input  logic [dtq_pkg::PER_W-1:0]  period_ms_i,
  input  logic                       repeats_i,
  input  logic                       restart_now_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [1:0]                 status_o,
  output logic [dtq_pkg::ID_W-1:0]   fired_id_o,
  output logic                       is_first_o,
  output logic [dtq_pkg::WAIT_W-1:0] wait_ms_o,
  output logic                       pending_o,
  output logic                       last_o
);
  import dtq_pkg::*;

  localparam int unsigned NW = $clog2(TIMERS + 1);
  localparam logic [TIME_BITS-1:0] DlMax = {{(TIME_BITS-1){1'b1}}, 1'b0};

  function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] base,
                                                   input logic [PER_W-1:0] ms);
    logic [TIME_BITS:0] s;
    s = {1'b0, base} + (TIME_BITS+1)'(ms);
    if ((base > DlMax) || (s > {1'b0, DlMax})) return DlMax;
    return s[TIME_BITS-1:0];
  endfunction

  state_e state_q, state_d;

  logic [2:0]           kind_q;
  logic [ID_W-1:0]      id_q;
  logic [TIME_BITS-1:0] now_q;
  logic [PER_W-1:0]     per_in_q;
  logic                 rep_in_q, fnow_q;

  logic [TIME_BITS-1:0] start_q, start_d, ins_dl_q, ins_dl_d;
  logic [PER_W-1:0]     per_q, per_d;
  logic                 rep_q, rep_d;
  logic [ID_W-1:0]      ins_id_q, ins_id_d;
  logic [SEQ_W-1:0]     cnt_q, cnt_d;
  logic [1:0]           rstat_q, rstat_d;
  logic                 rfront_q, rfront_d;
  logic [WAIT_W-1:0]    rwait_q, rwait_d;
  logic [NW-1:0]        n_q, n_d, k_q, k_d;

  logic [ID_W-1:0]  due_id_q  [TIMERS];
  logic [PER_W-1:0] due_per_q [TIMERS];
  logic             due_rep_q [TIMERS];

  logic                 out_valid_q;
  logic [1:0]           o_stat_q;
  logic [ID_W-1:0]      o_fid_q;
  logic                 o_front_q, o_pend_q, o_last_q;
  logic [WAIT_W-1:0]    o_wait_q;

  dtq_cmd_t             cmd;
  logic [ID_W-1:0]      rem_id;
  logic                 lk_hit, lk_rep, hd_valid, hd_rep, front;
  logic [TIME_BITS-1:0] lk_dl, hd_dl;
  logic [PER_W-1:0]     lk_per, hd_per;
  logic [ID_W-1:0]      hd_id;
  logic                 out_free, due_now, id_ok;
  logic                 do_push, do_rot, do_shift, ld_resp, ld_emit;

  dtq_chain #(.TIMERS(TIMERS), .TIME_BITS(TIME_BITS)) u_chain (
    .clk_i, .rst_ni, .cmd_i(cmd),
    .new_id_i(ins_id_q), .new_dl_i(ins_dl_q), .new_seq_i(cnt_q),
    .new_per_i(per_q), .new_rep_i(rep_q), .rem_id_i(rem_id), .lk_id_i(id_q),
    .lk_hit_o(lk_hit), .lk_dl_o(lk_dl), .lk_per_o(lk_per), .lk_rep_o(lk_rep),
    .hd_valid_o(hd_valid), .hd_id_o(hd_id), .hd_dl_o(hd_dl),
    .hd_per_o(hd_per), .hd_rep_o(hd_rep), .front_o(front)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);
  assign due_now    = hd_valid && (hd_dl <= now_q);
  assign rem_id     = (state_q == S_POP) ? hd_id : id_q;
  assign id_ok      = ({1'b0, id_q} < (ID_W+1)'(TIMERS));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_valid_i) state_d = S_DECODE;
      S_DECODE: begin
        priority if (kind_q == KIND_ADD) begin
          state_d = (!id_ok || lk_hit) ? S_RESP : S_REMOVE;
        end else if ((kind_q == KIND_CANCEL) || (kind_q == KIND_REFRESH) ||
                     (kind_q == KIND_RESET)) begin
          state_d = lk_hit ? S_REMOVE : S_RESP;
        end else if (kind_q == KIND_EXPIRE) begin
          state_d = S_POP;
        end else begin
          state_d = S_RESP;
        end
      end
      S_REMOVE: state_d = (kind_q == KIND_CANCEL) ? S_RESP : S_INSERT;
      S_INSERT: state_d = S_RESP;
      S_RESP:   if (out_free) state_d = S_IDLE;
      S_POP:    if (!due_now) state_d = (n_q == '0) ? S_RESP : S_RCALC;
      S_RCALC: begin
        if (k_q == n_q) state_d = S_EMIT;
        else if (due_rep_q[0]) state_d = S_RINS;
      end
      S_RINS:   state_d = S_RCALC;
      S_EMIT:   if (out_free && (n_q == NW'(1))) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // datapath and outputs of the sequencer
  always_comb begin
    cmd      = '0;
    start_d  = start_q;
    per_d    = per_q;
    rep_d    = rep_q;
    ins_id_d = ins_id_q;
    ins_dl_d = ins_dl_q;
    cnt_d    = cnt_q;
    rstat_d  = rstat_q;
    rfront_d = rfront_q;
    rwait_d  = rwait_q;
    n_d      = n_q;
    k_d      = k_q;
    do_push  = 1'b0;
    do_rot   = 1'b0;
    do_shift = 1'b0;
    ld_resp  = 1'b0;
    ld_emit  = 1'b0;
    unique case (state_q)
      S_DECODE: begin
        rstat_d  = ST_OK;
        rfront_d = 1'b0;
        rwait_d  = '0;
        ins_id_d = id_q;
        n_d      = '0;
        start_d  = now_q;
        per_d    = per_in_q;
        rep_d    = rep_in_q;
        priority if (kind_q == KIND_ADD) begin
          if (!id_ok || lk_hit) rstat_d = ST_BUSY;
        end else if ((kind_q == KIND_CANCEL) || (kind_q == KIND_REFRESH) ||
                     (kind_q == KIND_RESET)) begin
          if (!lk_hit) rstat_d = ST_NOT_PENDING;
          rep_d = lk_rep;
          if (kind_q == KIND_REFRESH) per_d = lk_per;
          if ((kind_q == KIND_RESET) && !fnow_q) begin
            start_d = (lk_dl >= TIME_BITS'(lk_per)) ? (lk_dl - TIME_BITS'(lk_per)) : '0;
          end
        end else if (kind_q == KIND_QUERY) begin
          if (!hd_valid) rwait_d = '1;
          else if (hd_dl <= now_q) rwait_d = '0;
          else rwait_d = WAIT_W'(hd_dl - now_q);
        end else begin
          rstat_d = ST_OK;
        end
      end
      S_REMOVE: begin
        cmd.rem  = 1'b1;
        ins_dl_d = sat_add(start_q, per_q);
        if (kind_q != KIND_CANCEL) cnt_d = cnt_q + 1'b1;
      end
      S_INSERT: begin
        cmd.ins  = 1'b1;
        rfront_d = front;
      end
      S_RESP: ld_resp = out_free;
      S_POP: begin
        if (due_now) begin
          cmd.rem = 1'b1;
          do_push = 1'b1;
          n_d     = n_q + 1'b1;
        end else begin
          k_d = '0;
          if (n_q == '0) rstat_d = ST_NONE_DUE;
        end
      end
      S_RCALC: begin
        if (k_q != n_q) begin
          do_rot = 1'b1;
          k_d    = k_q + 1'b1;
          if (due_rep_q[0]) begin
            ins_id_d = due_id_q[0];
            per_d    = due_per_q[0];
            rep_d    = 1'b1;
            ins_dl_d = sat_add(now_q, due_per_q[0]);
            cnt_d    = cnt_q + 1'b1;
          end
        end
      end
      S_RINS: cmd.ins = 1'b1;
      S_EMIT: begin
        if (out_free) begin
          ld_emit  = 1'b1;
          do_shift = 1'b1;
          n_d      = n_q - 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      n_q         <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      n_q     <= n_d;
      k_q     <= k_d;
      if (ld_resp || ld_emit) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_IDLE) && in_valid_i) begin
      kind_q   <= kind_i;
      id_q     <= timer_id_i;
      now_q    <= TIME_BITS'(now_ms_i);
      per_in_q <= period_ms_i;
      rep_in_q <= repeats_i;
      fnow_q   <= restart_now_i;
    end
    start_q  <= start_d;
    per_q    <= per_d;
    rep_q    <= rep_d;
    ins_id_q <= ins_id_d;
    ins_dl_q <= ins_dl_d;
    rstat_q  <= rstat_d;
    rfront_q <= rfront_d;
    rwait_q  <= rwait_d;
    if (ld_resp) begin
      o_stat_q  <= rstat_q;
      o_fid_q   <= '0;
      o_front_q <= rfront_q;
      o_wait_q  <= rwait_q;
      o_pend_q  <= hd_valid;
      o_last_q  <= 1'b1;
    end else if (ld_emit) begin
      o_stat_q  <= ST_OK;
      o_fid_q   <= due_id_q[0];
      o_front_q <= 1'b0;
      o_wait_q  <= '0;
      o_pend_q  <= hd_valid;
      o_last_q  <= (n_q == NW'(1));
    end
  end

  // due list: filled at the tail, rotated for rearm, drained from the front
  for (genvar i = 0; i < TIMERS; i++) begin : g_due
    always_ff @(posedge clk_i) begin
      if (do_push && (n_q == NW'(i))) begin
        due_id_q[i]  <= hd_id;
        due_per_q[i] <= hd_per;
        due_rep_q[i] <= hd_rep;
      end else if (do_rot) begin
        if (n_q == NW'(i + 1)) begin
          due_id_q[i]  <= due_id_q[0];
          due_per_q[i] <= due_per_q[0];
          due_rep_q[i] <= due_rep_q[0];
        end else if (i < TIMERS - 1) begin
          due_id_q[i]  <= due_id_q[(i + 1) % TIMERS];
          due_per_q[i] <= due_per_q[(i + 1) % TIMERS];
          due_rep_q[i] <= due_rep_q[(i + 1) % TIMERS];
        end
      end else if (do_shift && (i < TIMERS - 1)) begin
        due_id_q[i]  <= due_id_q[(i + 1) % TIMERS];
        due_per_q[i] <= due_per_q[(i + 1) % TIMERS];
        due_rep_q[i] <= due_rep_q[(i + 1) % TIMERS];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = o_stat_q;
  assign fired_id_o  = o_fid_q;
  assign is_first_o  = o_front_q;
  assign wait_ms_o   = o_wait_q;
  assign pending_o   = o_pend_q;
  assign last_o      = o_last_q;

  `DTQ_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)
  `DTQ_ASSERT_NOW(a_none_due_single, out_valid_o && (status_o == ST_NONE_DUE), last_o && (fired_id_o == '0))
  `DTQ_ASSERT_NOW(a_reject_not_front, out_valid_o && (status_o != ST_OK), !is_first_o)

endmodule
